/* rtl/rbsi_pkg.sv */
// Types and constants shared by the ray/box slab intersection pipeline
package rbsi_pkg;

  localparam int DataW  = 32;
  localparam int FracW  = 16;
  localparam int NumW   = DataW + 1 + FracW;  // (corner - origin) << 16, signed
  localparam int MagW   = NumW - 1;           // numerator magnitude bits
  localparam int DenW   = DataW;              // direction magnitude bits
  localparam int QuoW   = MagW;               // quotient magnitude bits
  localparam int RemW   = DenW + 1;

  // Quotient bits retired per divider stage; QuoW is a whole number of stages
  localparam int DivSteps  = 4;
  localparam int DivStages = QuoW / DivSteps;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SatMin = 32'sh80000000;

  typedef struct packed {
    logic signed [DataW-1:0] origin_x;
    logic signed [DataW-1:0] origin_y;
    logic signed [DataW-1:0] origin_z;
    logic signed [DataW-1:0] dir_x;
    logic signed [DataW-1:0] dir_y;
    logic signed [DataW-1:0] dir_z;
    logic signed [DataW-1:0] box_min_x;
    logic signed [DataW-1:0] box_min_y;
    logic signed [DataW-1:0] box_min_z;
    logic signed [DataW-1:0] box_max_x;
    logic signed [DataW-1:0] box_max_y;
    logic signed [DataW-1:0] box_max_z;
  } rbsi_in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] distance;
  } rbsi_out_t;

  // Per-axis slab bounds after division and ordering
  typedef struct packed {
    logic signed [DataW-1:0] entry;
    logic signed [DataW-1:0] exit_t;
  } rbsi_slab_t;

  // Division job carried down the divider stages
  typedef struct packed {
    logic [MagW-1:0] num;   // shifts out into the remainder, quotient shifts in
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic            neg;
  } rbsi_div_t;

  // Parallel-axis side information travelling beside the dividers
  typedef struct packed {
    logic par;
    logic enclosed;
  } rbsi_par_t;

  function automatic logic signed [DataW-1:0] sat_quo(input logic [QuoW-1:0] mag,
                                                       input logic neg);
    logic signed [DataW-1:0] res;
    begin
      if (neg) begin
        if (mag > QuoW'(33'h080000000)) res = SatMin;
        else res = DataW'(-$signed({1'b0, mag}));
      end else begin
        if (mag > QuoW'(32'h7fffffff)) res = SatMax;
        else res = DataW'(mag);
      end
      return res;
    end
  endfunction

endpackage

/* rtl/rbsi_div_stage.sv */
// One registered restoring-division stage: retires DivSteps quotient bits
module rbsi_div_stage (
  input  logic                clk,
  input  logic                en,
  input  rbsi_pkg::rbsi_div_t d_in,
  output rbsi_pkg::rbsi_div_t d_out
);
  import rbsi_pkg::*;

  rbsi_div_t job_nxt;
  rbsi_div_t job_r;
  logic [RemW:0] diff;

  always_comb begin
    job_nxt = d_in;
    diff    = '0;
    for (int i = 0; i < DivSteps; i++) begin
      job_nxt.rem = {job_nxt.rem[RemW-2:0], job_nxt.num[MagW-1]};
      diff        = {1'b0, job_nxt.rem} - {2'b0, job_nxt.den};
      if (!diff[RemW]) begin
        job_nxt.rem = diff[RemW-1:0];
        job_nxt.num = {job_nxt.num[MagW-2:0], 1'b1};
      end else begin
        job_nxt.num = {job_nxt.num[MagW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) job_r <= job_nxt;
  end

  assign d_out = job_r;
endmodule

/* rtl/rbsi_slab_div.sv */
// Pipelined signed slab-distance divider for one corner of one axis
module rbsi_slab_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [rbsi_pkg::DataW-1:0] corner,
  input  logic signed [rbsi_pkg::DataW-1:0] origin,
  input  logic signed [rbsi_pkg::DataW-1:0] dir,
  output logic signed [rbsi_pkg::DataW-1:0] quo
);
  import rbsi_pkg::*;

  logic signed [DataW:0] delta;
  logic signed [NumW-1:0] num;
  logic [MagW-1:0] num_mag;
  logic [DenW-1:0] den_mag;
  rbsi_div_t head;
  rbsi_div_t pipe [DivStages+1];

  always_comb begin
    delta   = {origin[DataW-1], origin} - {corner[DataW-1], corner};
    delta   = -delta;
    num     = {delta, {FracW{1'b0}}};
    num_mag = num[NumW-1] ? MagW'(-num) : MagW'(num);
    den_mag = dir[DataW-1] ? DenW'(-{dir[DataW-1], dir})
                           : DenW'({dir[DataW-1], dir});
    head.num = num_mag;
    head.rem = '0;
    head.den = den_mag;
    head.neg = num[NumW-1] ^ dir[DataW-1];
  end

  // den_mag can reach 2^31 which fits DenW bits; num_mag below 2^48 fits MagW bits
  assign pipe[0] = head;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    rbsi_div_stage u_stage (
      .clk  (clk),
      .en   (en),
      .d_in (pipe[s]),
      .d_out(pipe[s+1])
    );
  end

  assign quo = sat_quo(pipe[DivStages].num, pipe[DivStages].neg);
endmodule

/* rtl/ray_box_slab_intersect.sv */
// Top level: ray versus axis-aligned box slab test pipeline
// One transaction enters per cycle and one result leaves per cycle while out_stall
// is low. The pipeline is one input stage plus ceil(48/4) = 12 divider stages plus
// two compare stages; six 48-by-32-bit restoring dividers, four quotient bits per
// stage, set that depth. out_stall freezes the whole pipeline; in_stall follows it.
module ray_box_slab_intersect (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rbsi_pkg::rbsi_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rbsi_pkg::rbsi_out_t  out_data
);
  import rbsi_pkg::*;

  localparam int Lat = DivStages + 2;

  logic en;
  logic [Lat-1:0] vld_r, vld_nxt;
  rbsi_in_t in_r;
  rbsi_par_t par_pipe_r [DivStages][3];
  rbsi_par_t par_nxt [3];
  logic signed [DataW-1:0] q_lo [3];
  logic signed [DataW-1:0] q_hi [3];
  logic signed [DataW-1:0] org [3], dr [3], bmin [3], bmax [3];
  rbsi_slab_t slab_r [3], slab_nxt [3];
  logic out_valid_r;
  rbsi_out_t out_r, out_nxt;
  logic signed [DataW-1:0] tmin, tmax;

  assign en       = !out_stall;
  assign in_stall = out_stall;

  assign org  = '{in_r.origin_x, in_r.origin_y, in_r.origin_z};
  assign dr   = '{in_r.dir_x, in_r.dir_y, in_r.dir_z};
  assign bmin = '{in_r.box_min_x, in_r.box_min_y, in_r.box_min_z};
  assign bmax = '{in_r.box_max_x, in_r.box_max_y, in_r.box_max_z};

  always_ff @(posedge clk) begin
    if (en) in_r <= in_data;
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign par_nxt[a].par      = (dr[a] == '0);
    assign par_nxt[a].enclosed = (org[a] >= bmin[a]) && (org[a] <= bmax[a]);

    rbsi_slab_div u_lo (
      .clk(clk), .en(en), .corner(bmin[a]), .origin(org[a]), .dir(dr[a]), .quo(q_lo[a])
    );
    rbsi_slab_div u_hi (
      .clk(clk), .en(en), .corner(bmax[a]), .origin(org[a]), .dir(dr[a]), .quo(q_hi[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        par_pipe_r[0][a] <= par_nxt[a];
        for (int s = 1; s < DivStages; s++) par_pipe_r[s][a] <= par_pipe_r[s-1][a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (par_pipe_r[DivStages-1][a].par) begin
        slab_nxt[a].entry  = par_pipe_r[DivStages-1][a].enclosed ? SatMin : SatMax;
        slab_nxt[a].exit_t = par_pipe_r[DivStages-1][a].enclosed ? SatMax : SatMin;
      end else if (q_lo[a] < q_hi[a]) begin
        slab_nxt[a].entry  = q_lo[a];
        slab_nxt[a].exit_t = q_hi[a];
      end else begin
        slab_nxt[a].entry  = q_hi[a];
        slab_nxt[a].exit_t = q_lo[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) slab_r <= slab_nxt;
  end

  always_comb begin
    tmin = SatMin;
    tmax = SatMax;
    for (int a = 0; a < 3; a++) begin
      if (slab_r[a].entry > tmin) tmin = slab_r[a].entry;
      if (slab_r[a].exit_t < tmax) tmax = slab_r[a].exit_t;
    end
    if (tmax[DataW-1] || (tmin > tmax)) begin
      out_nxt.hit      = 1'b0;
      out_nxt.distance = tmax;
    end else begin
      out_nxt.hit      = 1'b1;
      out_nxt.distance = tmin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign vld_nxt = {vld_r[Lat-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[Lat-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
